// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the ChaCha20 stream cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clk edge while out of reset.
`define CC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cc20 assertion failed");

// Condition that must never be true.
`define CC_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cc20 forbidden condition seen");

`else

`define CC_ASSERT(label, prop)
`define CC_NEVER(label, cond)

`endif

`endif

// ----- hdl/cc20_pkg.sv -----
// Shared types, constants and round functions for the ChaCha20 stream cipher.
`default_nettype none

package cc20_pkg;

    // Sigma constant words
    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int RCNT_W        = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int WORD_BYTES    = 8;
    localparam int TDATA_W       = 72;

    localparam logic [3:0] FULL_COUNT = 4'd8;

    // Configuration register indexes
    localparam logic [2:0] CFG_KEY_0    = 3'd0;
    localparam logic [2:0] CFG_KEY_1    = 3'd1;
    localparam logic [2:0] CFG_KEY_2    = 3'd2;
    localparam logic [2:0] CFG_KEY_3    = 3'd3;
    localparam logic [2:0] CFG_NONCE_LO = 3'd4;
    localparam logic [2:0] CFG_NONCE_HI = 3'd5;
    localparam logic [2:0] CFG_INIT_CTR = 3'd6;

    typedef logic [31:0]       word32_t;
    typedef logic [15:0][31:0] cc_state_t;

    // One classified data word waiting for the back end
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        logic [2:0]  pos;
        logic        gen;
        word32_t     ctr;
    } qentry_t;

    // Block generator request and response
    typedef struct packed {
        logic    start;
        word32_t ctr;
    } core_req_t;

    typedef struct packed {
        logic      done;
        cc_state_t block;
    } core_rsp_t;

    typedef struct packed {
        word32_t a;
        word32_t b;
        word32_t c;
        word32_t d;
    } qr_t;

    function automatic word32_t rotl(input word32_t x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic qr_t quarter(input word32_t a, input word32_t b,
                                    input word32_t c, input word32_t d);
        qr_t q;
        q.a = a + b;   q.d = rotl(d ^ q.a, 16);
        q.c = c + q.d; q.b = rotl(b ^ q.c, 12);
        q.a = q.a + q.b; q.d = rotl(q.d ^ q.a, 8);
        q.c = q.c + q.d; q.b = rotl(q.b ^ q.c, 7);
        return q;
    endfunction

    // Column round followed by diagonal round
    function automatic cc_state_t double_round(input cc_state_t s);
        cc_state_t t;
        cc_state_t u;
        qr_t       q;
        for (int i = 0; i < 4; i++) begin
            q = quarter(s[i], s[4 + i], s[8 + i], s[12 + i]);
            t[i] = q.a; t[4 + i] = q.b; t[8 + i] = q.c; t[12 + i] = q.d;
        end
        for (int i = 0; i < 4; i++) begin
            q = quarter(t[i], t[4 + ((i + 1) & 3)], t[8 + ((i + 2) & 3)],
                        t[12 + ((i + 3) & 3)]);
            u[i] = q.a;
            u[4 + ((i + 1) & 3)]  = q.b;
            u[8 + ((i + 2) & 3)]  = q.c;
            u[12 + ((i + 3) & 3)] = q.d;
        end
        return u;
    endfunction

    // Initial state: constants, key, counter, nonce
    function automatic cc_state_t build_init(input logic [255:0] key,
                                             input word32_t ctr,
                                             input logic [95:0] nonce);
        cc_state_t s;
        s[0] = SIGMA_0; s[1] = SIGMA_1; s[2] = SIGMA_2; s[3] = SIGMA_3;
        for (int i = 0; i < 8; i++) begin
            s[4 + i] = key[32 * i +: 32];
        end
        s[12] = ctr;
        s[13] = nonce[31:0];
        s[14] = nonce[63:32];
        s[15] = nonce[95:64];
        return s;
    endfunction

    // Byte-enable mask for count valid low bytes (count already 1..8)
    function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
        logic [63:0] m;
        for (int i = 0; i < WORD_BYTES; i++) begin
            m[8 * i +: 8] = (i < int'(cnt)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cc20_front.sv -----
// Front end: accepts data words, assigns block counter and position, queues them.
`default_nettype none

`include "assert_macros.svh"

module cc20_front
    import cc20_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [TDATA_W-1:0]   s_tdata,   // [63:0] data_word, [67:64] byte_count
    input  wire logic                 s_tlast,   // last_of_message
    input  wire word32_t              initial_counter,
    output qentry_t                   head,
    output logic                      head_valid,
    input  wire logic                 pop
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    // Message tracking state
    word32_t     block_counter_reg, block_counter_next;
    logic [2:0]  word_position_reg, word_position_next;
    logic        message_start_reg, message_start_next;

    // Queue storage and pointers
    qentry_t         queue_mem [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    qentry_t     entry;
    logic        push;
    logic [3:0]  raw_count;

    // Classify the incoming word
    always_comb
    begin
        raw_count   = s_tdata[67:64];
        entry.data  = s_tdata[63:0];
        entry.count = (raw_count == 4'd0 || raw_count > FULL_COUNT) ? FULL_COUNT : raw_count;
        entry.last  = s_tlast;
        entry.ctr   = message_start_reg ? initial_counter : block_counter_reg;
        entry.pos   = message_start_reg ? 3'd0 : word_position_reg;
        entry.gen   = (entry.pos == 3'd0);
    end

    assign s_tready   = (count_reg != CntW'(QueueDepth));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign head       = queue_mem[rd_ptr_reg];

    // Next-state for message tracking and queue pointers
    always_comb
    begin
        block_counter_next = block_counter_reg;
        word_position_next = word_position_reg;
        message_start_next = message_start_reg;
        wr_ptr_next        = wr_ptr_reg;
        rd_ptr_next        = rd_ptr_reg;
        if (push)
        begin
            block_counter_next = entry.gen ? entry.ctr + 32'd1 : entry.ctr;
            word_position_next = entry.pos + 3'd1;
            message_start_next = s_tlast;
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_counter_reg <= '0;
            word_position_reg <= '0;
            message_start_reg <= 1'b1;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            count_reg         <= '0;
        end
        else
        begin
            block_counter_reg <= block_counter_next;
            word_position_reg <= word_position_next;
            message_start_reg <= message_start_next;
            wr_ptr_reg        <= wr_ptr_next;
            rd_ptr_reg        <= rd_ptr_next;
            count_reg         <= count_next;
        end
    end

    // Queue write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= entry;
        end
    end

    `CC_ASSERT(a_queue_bound, count_reg <= CntW'(QueueDepth))
    `CC_NEVER(a_pop_empty, pop && (count_reg == '0))

endmodule

`default_nettype wire

// ----- hdl/cc20_core.sv -----
// Keystream block generator: one double round per cycle plus feed-forward add.
`default_nettype none

module cc20_core
    import cc20_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [255:0]  key,
    input  wire logic [95:0]   nonce,
    input  wire core_req_t     req,
    output core_rsp_t          rsp
);

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINAL
    } core_state_t;

    core_state_t       fsm_reg, fsm_next;
    logic [RCNT_W-1:0] rcnt_reg, rcnt_next;
    logic              done_reg, done_next;
    word32_t           ctr_reg, ctr_next;
    cc_state_t         st_reg, st_next;
    cc_state_t         init_words;

    // Init rebuilt for feed-forward; user keeps config stable while busy, unchecked
    assign init_words = build_init(key, ctr_reg, nonce);

    always_comb
    begin
        fsm_next  = fsm_reg;
        rcnt_next = rcnt_reg;
        done_next = 1'b0;
        ctr_next  = ctr_reg;
        st_next   = st_reg;
        case (fsm_reg)
            CORE_IDLE:
            begin
                if (req.start)
                begin
                    st_next   = build_init(key, req.ctr, nonce);
                    ctr_next  = req.ctr;
                    rcnt_next = '0;
                    fsm_next  = CORE_ROUND;
                end
            end
            CORE_ROUND:
            begin
                st_next = double_round(st_reg);
                if (rcnt_reg == RCNT_W'(DOUBLE_ROUNDS - 1))
                begin
                    fsm_next = CORE_FINAL;
                end
                else
                begin
                    rcnt_next = rcnt_reg + 1'b1;
                end
            end
            CORE_FINAL:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    st_next[i] = st_reg[i] + init_words[i];
                end
                done_next = 1'b1;
                fsm_next  = CORE_IDLE;
            end
            default:
            begin
                fsm_next = CORE_IDLE;
            end
        endcase
    end

    // Control state and registered done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg  <= CORE_IDLE;
            rcnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fsm_reg  <= fsm_next;
            rcnt_reg <= rcnt_next;
            done_reg <= done_next;
        end
    end

    // Working state
    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        ctr_reg <= ctr_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.block = st_reg;

endmodule

`default_nettype wire

// ----- hdl/cc20_back.sv -----
// Back end: keystream store, block requests, XOR and output register.
`default_nettype none

`include "assert_macros.svh"

module cc20_back
    import cc20_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [255:0]        key,
    input  wire logic [95:0]         nonce,
    input  wire qentry_t             head,
    input  wire logic                head_valid,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata,   // [63:0] result_word, [67:64] result_count
    output logic                     m_tlast    // result_last
);

    logic [7:0][63:0] keystream_store_reg;
    logic             ks_fresh_reg, ks_fresh_next;
    logic             busy_reg, busy_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      result_reg;
    logic [3:0]       result_count_reg;
    logic             result_last_reg;

    core_req_t   req;
    core_rsp_t   rsp;
    logic [63:0] ks_word;
    logic        slot_free;
    logic        gen_ok;

    cc20_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (key),
        .nonce (nonce),
        .req   (req),
        .rsp   (rsp)
    );

    // Issue and pop decisions
    always_comb
    begin
        ks_word   = keystream_store_reg[head.pos];
        gen_ok    = !head.gen || ks_fresh_reg;
        slot_free = !out_valid_reg || m_tready;
        pop       = head_valid && gen_ok && slot_free;
        req.start = head_valid && head.gen && !ks_fresh_reg && !busy_reg;
        req.ctr   = head.ctr;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
        end
        else if (rsp.done)
        begin
            busy_next = 1'b0;
        end

        ks_fresh_next = ks_fresh_reg;
        if (rsp.done)
        begin
            ks_fresh_next = 1'b1;
        end
        else if (pop && head.gen)
        begin
            ks_fresh_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            ks_fresh_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            ks_fresh_reg  <= ks_fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Keystream capture and output payload
    always_ff @(posedge clk)
    begin
        if (rsp.done)
        begin
            keystream_store_reg <= rsp.block;
        end
        if (pop)
        begin
            result_reg       <= (head.data ^ ks_word) & byte_mask(head.count);
            result_count_reg <= head.count;
            result_last_reg  <= head.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, result_count_reg, result_reg};
    assign m_tlast  = result_last_reg;

    `CC_ASSERT(a_done_while_busy, rsp.done |-> busy_reg)
    `CC_ASSERT(a_fresh_from_core, $rose(ks_fresh_reg) |-> $past(rsp.done))
    `CC_NEVER(a_done_gen_pop, rsp.done && pop && head.gen)

endmodule

`default_nettype wire

// ----- hdl/chacha20_stream_cipher.sv -----
// Top level of the ChaCha20 stream cipher: config registers, front and back ends.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  s_*      | s_tvalid/s_tready | s_tdata: data_word, byte_count; s_tlast
//  m_*      | m_tvalid/m_tready | m_tdata: result_word, result_count; m_tlast
//  cfg_*    | cfg_we            | cfg_index, cfg_data (no read-back)
//
// A word whose keystream block is already held passes through the queue and the output
// register before it shows up on m_*; such words stream at one per cycle while m_tready
// is high. The first word of each 64-byte block waits for the block generator
// (load, 10 double rounds, feed-forward, capture), started once it heads the queue.
// Reset is asynchronous, active low; no clearing pass is needed.
// A 4-entry queue between front and back keeps input and output stalls apart.
`default_nettype none

module chacha20_stream_cipher
    import cc20_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [TDATA_W-1:0]  s_tdata,   // [63:0] data_word, [67:64] byte_count
    input  wire logic                s_tlast,   // last_of_message
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata,   // [63:0] result_word, [67:64] result_count
    output logic                     m_tlast,   // result_last
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [63:0]         cfg_data
);

    logic [255:0] key_reg;
    logic [95:0]  nonce_reg;
    word32_t      init_ctr_reg;

    qentry_t head;
    logic    head_valid;
    logic    pop;

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= '0;
            nonce_reg    <= '0;
            init_ctr_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_0:    key_reg[63:0]    <= cfg_data;
                CFG_KEY_1:    key_reg[127:64]  <= cfg_data;
                CFG_KEY_2:    key_reg[191:128] <= cfg_data;
                CFG_KEY_3:    key_reg[255:192] <= cfg_data;
                CFG_NONCE_LO: nonce_reg[63:0]  <= cfg_data;
                CFG_NONCE_HI: nonce_reg[95:64] <= cfg_data[31:0];
                CFG_INIT_CTR: init_ctr_reg     <= cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    cc20_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .initial_counter (init_ctr_reg),
        .head            (head),
        .head_valid      (head_valid),
        .pop             (pop)
    );

    cc20_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key_reg),
        .nonce      (nonce_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
